// ===== design/sld_pkg.sv =====
// Shared types, codes and default sizes of the server load dispatcher.
package sld_pkg;

    localparam int DEF_QUEUE_DEPTH = 128;
    localparam int DEF_NUM_SERVERS = 3;

    localparam logic [2:0] LIMIT_RESET = 3'd5;

    localparam logic [1:0] KIND_OTHER    = 2'd0;
    localparam logic [1:0] KIND_REQUEST  = 2'd1;
    localparam logic [1:0] KIND_RESPONSE = 2'd2;

    typedef enum logic [2:0] {
        ACT_PASS    = 3'd0,
        ACT_FORWARD = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_QUEUED  = 3'd3,
        ACT_DROP    = 3'd4
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== design/sld_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ===== design/server_load_dispatcher.sv =====
// Server load dispatcher: picks a server for each client request, or queues its byte.
//
// Each accepted beat is taken into the input registers in ST_IDLE, while the head
// entry of the request queue is read from its RAM; in ST_EXEC the decision is made,
// the busy counts and queue pointers are updated and the result is loaded into the
// output register. The registered read of the queue RAM is why the decision waits
// for ST_EXEC. A result that waits in the output register holds the block in
// ST_EXEC until it is taken, so a stalled output also holds back the next beat. The
// queue needs no clearing after reset; thread_limit can be written at any time the
// block is idle and its write is always taken at once.
module server_load_dispatcher
    import sld_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int NUM_SERVERS = DEF_NUM_SERVERS,
    parameter int SID_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       thread_limit,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       kind,
    input  logic [SID_W-1:0] server_id,
    input  logic             payload_present,
    input  logic [7:0]       request_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       action,
    output logic [SID_W-1:0] target_server,
    output logic [7:0]       send_byte
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(QUEUE_DEPTH);

    state_t state_reg, state_next;

    logic [2:0]        limit_reg;
    logic [2:0]        busy_reg [NUM_SERVERS];
    logic [2:0]        busy_next [NUM_SERVERS];
    logic [PTR_W-1:0]  head_reg, tail_reg;
    logic [FILL_W-1:0] fill_reg;

    logic [1:0]        kind_reg;
    logic [SID_W-1:0]  sid_reg;
    logic              payload_reg;
    logic [7:0]        byte_reg;

    logic              out_valid_reg;
    action_t           action_reg, action_next;
    logic [SID_W-1:0]  target_reg, target_next;
    logic [7:0]        send_reg, send_next;

    logic              accept;
    logic              fire;
    logic              push, pop;
    logic [7:0]        head_data;

    assign cfg_ready     = 1'b1;
    assign in_stall      = (state_reg != ST_IDLE);
    assign accept        = in_valid && !in_stall;
    assign fire          = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign out_valid     = out_valid_reg;
    assign action        = action_reg;
    assign target_server = target_reg;
    assign send_byte     = send_reg;

    // The head is read every cycle; it only moves in a decision cycle, so the
    // data seen there always belongs to the current head.
    sld_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH),
        .ADDR_W(PTR_W)
    ) u_queue_ram (
        .clk    (clk),
        .wr_en  (push),
        .wr_addr(tail_reg),
        .wr_data(byte_reg),
        .rd_addr(head_reg),
        .rd_data(head_data)
    );

    always_comb
    begin
        logic             found;
        logic [SID_W-1:0] pick;
        logic             sid_ok;
        logic [2:0]       cur;

        found       = 1'b0;
        pick        = '0;
        sid_ok      = (int'(sid_reg) < NUM_SERVERS);
        cur         = '0;
        state_next  = state_reg;
        action_next = ACT_PASS;
        target_next = '0;
        send_next   = '0;
        push        = 1'b0;
        pop         = 1'b0;
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            busy_next[i] = busy_reg[i];
            if (sid_reg == SID_W'(i))
            begin
                cur = busy_reg[i];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
                case (kind_reg)
                    KIND_REQUEST:
                    begin
                        if (payload_reg)
                        begin
                            // Lowest-numbered server below the limit wins.
                            for (int i = NUM_SERVERS - 1; i >= 0; i--)
                            begin
                                if (busy_reg[i] < limit_reg)
                                begin
                                    found = 1'b1;
                                    pick  = SID_W'(i);
                                end
                            end
                            if (found)
                            begin
                                action_next = ACT_FORWARD;
                                target_next = pick;
                                for (int i = 0; i < NUM_SERVERS; i++)
                                begin
                                    if (pick == SID_W'(i))
                                    begin
                                        busy_next[i] = busy_reg[i] + 3'd1;
                                    end
                                end
                            end
                            else if (fill_reg < FILL_FULL)
                            begin
                                action_next = ACT_QUEUED;
                                push        = fire;
                            end
                            else
                            begin
                                action_next = ACT_DROP;
                            end
                        end
                    end
                    KIND_RESPONSE:
                    begin
                        if (sid_ok && (cur != 3'd0))
                        begin
                            if ((fill_reg != '0) && (cur < limit_reg))
                            begin
                                // A response without a payload slot cannot
                                // carry the queued byte, so the byte stays.
                                if (payload_reg)
                                begin
                                    action_next = ACT_SEND;
                                    target_next = sid_reg;
                                    send_next   = head_data;
                                    pop         = fire;
                                end
                                else
                                begin
                                    action_next = ACT_DROP;
                                end
                            end
                            else
                            begin
                                for (int i = 0; i < NUM_SERVERS; i++)
                                begin
                                    if (sid_reg == SID_W'(i))
                                    begin
                                        busy_next[i] = busy_reg[i] - 3'd1;
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                        action_next = ACT_PASS;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SERVERS; i++)
            begin
                busy_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= thread_limit;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < NUM_SERVERS; i++)
                begin
                    busy_reg[i] <= busy_next[i];
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (push)
            begin
                tail_reg <= (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (pop)
            begin
                head_reg <= (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            sid_reg     <= server_id;
            payload_reg <= payload_present;
            byte_reg    <= request_byte;
        end
        if (fire)
        begin
            action_reg <= action_next;
            target_reg <= target_next;
            send_reg   <= send_next;
        end
    end

endmodule

// ===== verif/server_load_dispatcher_tb.sv =====
// Self-checking testbench of the server load dispatcher: random beats against a predictor.
module server_load_dispatcher_tb;
    import sld_pkg::*;

    localparam int NSRV = DEF_NUM_SERVERS;
    localparam int QDEPTH = DEF_QUEUE_DEPTH;
    localparam int STALL_PCT = 6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] SID_OUT_OF_RANGE = 2'd3;

    typedef struct {
        logic [1:0] kind;
        logic [1:0] sid;
        logic       with_payload;
        logic [7:0] data;
    } packet_t;

    typedef struct {
        action_t    act;
        logic [1:0] srv;
        logic [7:0] data;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] thread_limit = LIMIT_RESET;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] kind = KIND_OTHER;
    logic [1:0] server_id = 2'd0;
    logic       payload_present = 1'b0;
    logic [7:0] request_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] action;
    logic [1:0] target_server;
    logic [7:0] send_byte;

    // Predictor state: busy threads per server, the pending request bytes and the limit.
    logic [2:0] busy [NSRV];
    logic [7:0] waiting_bytes [$];
    logic [2:0] limit_now = LIMIT_RESET;

    packet_t  packets_to_send [$];
    verdict_t verdicts_due [$];
    logic [2:0] limit_writes [$];
    packet_t  on_wire;
    bit       no_gaps = 1'b0;
    int       mismatches = 0;
    int       idle_cycles = 0;

    server_load_dispatcher dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .thread_limit    (thread_limit),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .server_id       (server_id),
        .payload_present (payload_present),
        .request_byte    (request_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .action          (action),
        .target_server   (target_server),
        .send_byte       (send_byte)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (busy[i])
            busy[i] = 3'd0;
    end

    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic verdict_t dispatch_verdict(packet_t p);
        verdict_t v;
        bit placed;
        v.act = ACT_PASS;
        v.srv = 2'd0;
        v.data = 8'd0;
        placed = 1'b0;
        if (p.kind == KIND_REQUEST && p.with_payload)
        begin
            for (int s = 0; s < NSRV; s++)
            begin
                if (!placed && busy[s] < limit_now)
                begin
                    busy[s] = busy[s] + 3'd1;
                    v.act = ACT_FORWARD;
                    v.srv = s[1:0];
                    placed = 1'b1;
                end
            end
            if (!placed)
            begin
                if (waiting_bytes.size() < QDEPTH)
                begin
                    waiting_bytes.push_back(p.data);
                    v.act = ACT_QUEUED;
                end
                else
                    v.act = ACT_DROP;
            end
        end
        else if (p.kind == KIND_RESPONSE && p.sid < NSRV && busy[p.sid] != 3'd0)
        begin
            // A free slot on the responding server takes the oldest waiting byte.
            if (waiting_bytes.size() != 0 && busy[p.sid] < limit_now)
            begin
                if (p.with_payload)
                begin
                    v.data = waiting_bytes.pop_front();
                    v.act = ACT_SEND;
                    v.srv = p.sid;
                end
                else
                    v.act = ACT_DROP;
            end
            else
                busy[p.sid] = busy[p.sid] - 3'd1;
        end
        return v;
    endfunction

    function automatic packet_t random_packet(int req_pct, int resp_pct);
        packet_t p;
        int roll;
        roll = $urandom_range(99);
        if (roll < req_pct)
            p.kind = KIND_REQUEST;
        else if (roll < req_pct + resp_pct)
            p.kind = KIND_RESPONSE;
        else
            p.kind = ($urandom_range(1) == 0) ? KIND_OTHER : KIND_UNUSED;
        p.sid = ($urandom_range(99) < 5) ? SID_OUT_OF_RANGE : 2'($urandom_range(NSRV - 1));
        p.with_payload = ($urandom_range(99) < 88);
        p.data = 8'($urandom);
        return p;
    endfunction

    // Configuration writes: one beat at a time, taken into the predictor when accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_valid <= 1'b0;
        else if (cfg_valid && cfg_ready)
        begin
            limit_now = thread_limit;
            cfg_valid <= 1'b0;
        end
        else if (!cfg_valid && limit_writes.size() != 0)
        begin
            thread_limit <= limit_writes.pop_front();
            cfg_valid <= 1'b1;
        end
    end

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                verdicts_due.push_back(dispatch_verdict(on_wire));
            if (!in_valid || !in_stall)
            begin
                if (packets_to_send.size() != 0
                    && (no_gaps || $urandom_range(99) >= STALL_PCT))
                begin
                    on_wire = packets_to_send.pop_front();
                    kind <= on_wire.kind;
                    server_id <= on_wire.sid;
                    payload_present <= on_wire.with_payload;
                    request_byte <= on_wire.data;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        verdict_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch($sformatf("result with action %0d and nothing outstanding",
                                              action));
                else
                begin
                    want = verdicts_due.pop_front();
                    if (action !== want.act)
                        report_mismatch($sformatf("action %0d, expected %s", action,
                                                  want.act.name()));
                    if (target_server !== want.srv)
                        report_mismatch($sformatf("target_server %0d, expected %0d",
                                                  target_server, want.srv));
                    if (send_byte !== want.data)
                        report_mismatch($sformatf("send_byte %02h, expected %02h",
                                                  send_byte, want.data));
                end
            end
            out_stall <= !no_gaps && ($urandom_range(99) < STALL_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat accepted for %0d cycles", idle_cycles);
            $display("** server_load_dispatcher: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic add_packet(logic [1:0] k, logic [1:0] sid, logic pay, logic [7:0] data);
        packet_t p;
        p.kind = k;
        p.sid = sid;
        p.with_payload = pay;
        p.data = data;
        packets_to_send.push_back(p);
    endtask

    task automatic add_random_packets(int count, int req_pct, int resp_pct);
        repeat (count)
            packets_to_send.push_back(random_packet(req_pct, resp_pct));
    endtask

    // Holds the sender back until every beat has gone in and every result has come out.
    task automatic wait_for_quiet();
        do
            @(negedge clk);
        while (packets_to_send.size() != 0 || in_valid || verdicts_due.size() != 0);
    endtask

    task automatic write_limit(logic [2:0] value);
        wait_for_quiet();
        limit_writes.push_back(value);
        do
            @(negedge clk);
        while (limit_writes.size() != 0 || cfg_valid);
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: with a limit of two, bytes are queued and then drained by responses.
        write_limit(3'd2);
        add_packet(KIND_OTHER, 2'd0, 1'b1, 8'hFF);
        add_packet(KIND_UNUSED, SID_OUT_OF_RANGE, 1'b1, 8'h00);
        add_packet(KIND_REQUEST, 2'd0, 1'b0, 8'h11);
        add_packet(KIND_RESPONSE, 2'd0, 1'b1, 8'h22);
        add_packet(KIND_RESPONSE, SID_OUT_OF_RANGE, 1'b1, 8'h33);
        add_packet(KIND_REQUEST, 2'd1, 1'b1, 8'h00);
        add_packet(KIND_REQUEST, 2'd2, 1'b1, 8'hFF);
        add_packet(KIND_REQUEST, 2'd0, 1'b1, 8'h01);
        add_packet(KIND_REQUEST, 2'd0, 1'b1, 8'h80);
        add_packet(KIND_REQUEST, 2'd0, 1'b1, 8'h7F);
        add_packet(KIND_REQUEST, 2'd0, 1'b1, 8'hFE);
        add_packet(KIND_REQUEST, 2'd0, 1'b1, 8'hA5);
        add_packet(KIND_REQUEST, 2'd0, 1'b1, 8'h5A);
        add_packet(KIND_RESPONSE, 2'd0, 1'b1, 8'h00);
        add_packet(KIND_RESPONSE, 2'd0, 1'b1, 8'h00);
        add_packet(KIND_RESPONSE, 2'd0, 1'b0, 8'h00);
        add_packet(KIND_RESPONSE, 2'd0, 1'b1, 8'h00);
        add_packet(KIND_RESPONSE, 2'd0, 1'b1, 8'h00);
        add_packet(KIND_RESPONSE, 2'd0, 1'b1, 8'h00);
        // A limit of zero leaves no server free, and counts above it only fall.
        write_limit(3'd0);
        add_packet(KIND_REQUEST, 2'd0, 1'b1, 8'h3C);
        add_packet(KIND_RESPONSE, 2'd1, 1'b0, 8'h00);
        add_packet(KIND_REQUEST, 2'd0, 1'b0, 8'hC3);
        write_limit(3'd7);
        add_packet(KIND_REQUEST, 2'd0, 1'b1, 8'hC3);
        add_packet(KIND_RESPONSE, 2'd2, 1'b1, 8'h00);
        add_packet(KIND_RESPONSE, 2'd2, 1'b1, 8'h00);

        write_limit(3'd3);
        add_random_packets(100, 45, 40);
        wait_for_quiet();
        add_random_packets(100, 45, 40);

        // A stretch with no idling on either side.
        write_limit(3'd1);
        no_gaps = 1'b1;
        add_random_packets(150, 50, 40);
        wait_for_quiet();
        no_gaps = 1'b0;

        // Nothing is free, so requests pile up in the queue.
        write_limit(3'd0);
        add_random_packets(150, 95, 4);

        // A high limit lets responses drain the queue.
        write_limit(3'd7);
        add_random_packets(250, 35, 60);

        write_limit(3'd4);
        add_random_packets(100, 45, 45);

        wait_for_quiet();
        repeat (20)
            @(posedge clk);
        if (mismatches == 0)
            $display("** server_load_dispatcher: PASSED **");
        else
            $display("** server_load_dispatcher: FAILED **");
        $finish;
    end

endmodule
